>>> hw/rtl/mlpd_pkg.sv
// Package for the length-prefixed deframer: phase codes, header constants,
// deframer state and per-byte result types. No dependencies.
package mlpd_pkg;

  // Frame header bytes ('Y', 'H')
  localparam logic [7:0] HdrFirst  = 8'h59;
  localparam logic [7:0] HdrSecond = 8'h48;

  // Register reset value for the largest accepted body length
  localparam logic [30:0] MaxBodyLenReset = 31'd65536;

  // Byte positions inside the length word
  localparam logic [1:0] LenPosLast = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  pair_first;
    logic [1:0]  byte_pos;
    logic [31:0] len_acc;
    logic [30:0] body_rem;
  } dfr_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] body_byte;
    logic       last;
    logic       empty;
  } dfr_result_t;

  localparam dfr_state_t StateReset = '{
    phase:      PH_HEADER,
    pair_first: 8'h00,
    byte_pos:   2'd0,
    len_acc:    32'h0,
    body_rem:   31'h0
  };

endpackage

>>> hw/rtl/magic_length_prefixed_deframer_unit.sv
// Top level of the length-prefixed deframer: input register, step logic,
// output register and the max body length register. Depends on mlpd_pkg, mlpd_step.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, rx_byte_i) takes one stream byte
//   per request. Frames are 'Y','H', a 4-byte little-endian signed length,
//   then the body. Output channel (out_valid_o / out_stall_i) delivers one
//   body byte per request with frame_last_o on the final byte; a zero-length
//   frame gives one request with frame_empty_o and frame_last_o set.
//   Header, length bytes and dropped frames give no output request.
//   Config channel (cfg_valid_i / cfg_ready_o) writes max_body_length; it is
//   always ready; the user must write it only while the block is idle, which
//   the block itself does not enforce. A body byte passes from the input
//   register through the combinational step logic to the output register.
//   Throughput: one byte per cycle while the output is not stalled.
//   Reset: header phase, all counters zero, max_body_length = 65536.
//   When the receiver stalls, the output register holds its request; an empty
//   input register still takes one more byte, then in_stall_o is raised.
module magic_length_prefixed_deframer_unit import mlpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  body_byte_o,
  output logic        frame_last_o,
  output logic        frame_empty_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_max_body_length_i
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  body_byte_q;
  logic        last_q, empty_q;
  logic [30:0] max_len_q;
  dfr_state_t  state_q, state_d;
  dfr_result_t result;
  logic        in_accept, advance;

  // Handshake control
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = result.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Step logic
  mlpd_step u_step (
    .state_i   (state_q),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (result)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
      max_len_q   <= MaxBodyLenReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_body_length_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && result.valid) begin
      body_byte_q <= result.body_byte;
      last_q      <= result.last;
      empty_q     <= result.empty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign body_byte_o   = body_byte_q;
  assign frame_last_o  = last_q;
  assign frame_empty_o = empty_q;

  // Empty-frame marker is always the last result of its frame with a zero byte
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_empty_o |-> frame_last_o && (body_byte_o == 8'h00))
    else $error("empty marker without last flag or with nonzero byte");

  // In the body phase at least one body byte is still due
  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_BODY |-> state_q.body_rem != 31'h0)
    else $error("body phase with zero remaining count");

  // Header pair position never exceeds one
  a_header_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_HEADER |-> !state_q.byte_pos[1])
    else $error("header phase with length word position");

endmodule

>>> hw/rtl/mlpd_step.sv
// Per-byte step logic of the deframer: next state and optional result.
// Depends on mlpd_pkg.
module mlpd_step import mlpd_pkg::*; (
  input  dfr_state_t  state_i,
  input  logic [7:0]  byte_i,
  input  logic [30:0] max_len_i,
  output dfr_state_t  state_o,
  output dfr_result_t result_o
);

  logic [31:0] len_new;

  // Merge the incoming byte into the little-endian length word
  always_comb begin
    len_new = state_i.len_acc | ({24'h0, byte_i} << {state_i.byte_pos, 3'b000});
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, body_byte: 8'h00, last: 1'b0, empty: 1'b0};
    unique case (state_i.phase)
      PH_LENGTH: begin
        state_o.len_acc = len_new;
        if (state_i.byte_pos != LenPosLast) begin
          state_o.byte_pos = state_i.byte_pos + 2'd1;
        end else begin
          state_o.byte_pos = 2'd0;
          // negative or oversized: drop the frame
          if (len_new[31] || (len_new[30:0] > max_len_i)) begin
            state_o.phase   = PH_HEADER;
            state_o.len_acc = 32'h0;
          end else if (len_new == 32'h0) begin
            state_o.phase   = PH_HEADER;
            result_o.valid  = 1'b1;
            result_o.last   = 1'b1;
            result_o.empty  = 1'b1;
          end else begin
            state_o.body_rem = len_new[30:0];
            state_o.len_acc  = 32'h0;
            state_o.phase    = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        state_o.body_rem   = state_i.body_rem - 31'd1;
        result_o.valid     = 1'b1;
        result_o.body_byte = byte_i;
        result_o.last      = (state_o.body_rem == 31'h0);
        if (state_o.body_rem == 31'h0) begin
          state_o.phase    = PH_HEADER;
          state_o.byte_pos = 2'd0;
        end
      end
      default: begin
        // header phase; the unused code behaves the same
        state_o.phase = PH_HEADER;
        if (!state_i.byte_pos[0]) begin
          state_o.pair_first = byte_i;
          state_o.byte_pos   = 2'd1;
        end else begin
          state_o.byte_pos = 2'd0;
          if (state_i.pair_first == HdrFirst && byte_i == HdrSecond) begin
            state_o.phase   = PH_LENGTH;
            state_o.len_acc = 32'h0;
          end
        end
      end
    endcase
  end

endmodule
